@@ hdl/dda_pkg.sv @@
`timescale 1ns / 1ps

package dda_pkg;

  // Operation codes carried on the op field.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // start item transferred this cycle
    logic advance;   // advance item transferred this cycle
    logic div_step;  // retire one quotient bit of both divisions
  } dda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_len;  // endpoints on the input ports coincide
    logic div_last;  // the current division step is the final one
  } dda_status_t;

endpackage

@@ hdl/dda_ctrl.sv @@
`timescale 1ns / 1ps

module dda_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dda_pkg::dda_status_t status,
  output dda_pkg::dda_cmd_t    cmd
);
  import dda_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DIVIDE
  } state_t;

  state_t state;
  logic   accept;

  // A new item may enter in the same cycle as the held result is transferred.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.start    = accept && (op == OP_START);
    cmd.advance  = accept && (op == OP_ADVANCE);
    cmd.div_step = (state == S_DIVIDE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Every accepted item writes exactly one result into the output register.
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.start && !status.zero_len) begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (status.div_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/dda_dpath.sv @@
`timescale 1ns / 1ps

module dda_dpath #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dda_pkg::dda_cmd_t           cmd,
  output dda_pkg::dda_status_t        status,
  input  logic [COORD_BITS-1:0]       start_x,
  input  logic [COORD_BITS-1:0]       start_y,
  input  logic [COORD_BITS-1:0]       end_x,
  input  logic [COORD_BITS-1:0]       end_y,
  output logic                        valid_res,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_x,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_y,
  output logic                        last
);
  import dda_pkg::*;

  localparam int POS_W = COORD_BITS + FRAC_BITS;
  localparam int INC_W = FRAC_BITS + 2;
  localparam int SUM_W = POS_W + 2;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(FRAC_BITS);
  localparam logic [POS_W-1:0] POS_MAX = {{COORD_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

  // Line state
  logic                   line_active;
  logic [POS_W-1:0]       x_accum, y_accum;
  logic signed [INC_W-1:0] x_step_inc, y_step_inc;
  logic [COORD_BITS:0]    points_left;

  // Shared divider state: both increments are divided by the same step count.
  logic [COORD_BITS-1:0]  divisor;
  logic [COORD_BITS:0]    rem_x, rem_y;
  logic [FRAC_BITS:0]     quo_x, quo_y;
  logic                   neg_x, neg_y;
  logic [CNT_W-1:0]       bit_cnt;

  // Start decode
  logic [COORD_BITS-1:0]  adx, ady, steps;

  always_comb begin
    adx   = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
    ady   = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
    steps = (adx > ady) ? adx : ady;
    status.zero_len = (steps == '0);
    status.div_last = (bit_cnt == '0);
  end

  // One restoring step per cycle. The first step weighs 1.0 and needs no shift,
  // since the delta never exceeds the step count.
  logic                   first_bit;
  logic [COORD_BITS:0]    shx, shy, rem_x_next, rem_y_next;
  logic                   ge_x, ge_y;
  logic [FRAC_BITS:0]     quo_x_next, quo_y_next;

  always_comb begin
    first_bit  = (bit_cnt == CNT_TOP);
    shx        = first_bit ? rem_x : {rem_x[COORD_BITS-1:0], 1'b0};
    shy        = first_bit ? rem_y : {rem_y[COORD_BITS-1:0], 1'b0};
    ge_x       = (shx >= {1'b0, divisor});
    ge_y       = (shy >= {1'b0, divisor});
    rem_x_next = ge_x ? (shx - {1'b0, divisor}) : shx;
    rem_y_next = ge_y ? (shy - {1'b0, divisor}) : shy;
    quo_x_next = {quo_x[FRAC_BITS-1:0], ge_x};
    quo_y_next = {quo_y[FRAC_BITS-1:0], ge_y};
  end

  // Advance: add the signed increment and clamp to the screen range.
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [POS_W-1:0]        new_x, new_y;
  logic [COORD_BITS:0]     points_left_next;

  always_comb begin
    sum_x = signed'({2'b00, x_accum}) + SUM_W'(x_step_inc);
    sum_y = signed'({2'b00, y_accum}) + SUM_W'(y_step_inc);
    if (sum_x < 0) begin
      new_x = '0;
    end else if (sum_x > signed'({2'b00, POS_MAX})) begin
      new_x = POS_MAX;
    end else begin
      new_x = sum_x[POS_W-1:0];
    end
    if (sum_y < 0) begin
      new_y = '0;
    end else if (sum_y > signed'({2'b00, POS_MAX})) begin
      new_y = POS_MAX;
    end else begin
      new_y = sum_y[POS_W-1:0];
    end
    points_left_next = (points_left != '0) ? (points_left - 1'b1) : points_left;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      points_left <= '0;
      bit_cnt     <= '0;
    end else begin
      if (cmd.start) begin
        line_active <= !status.zero_len;
        points_left <= {1'b0, steps};
        bit_cnt     <= CNT_TOP;
      end else if (cmd.advance && line_active) begin
        points_left <= points_left_next;
        line_active <= (points_left_next != '0);
      end
      if (cmd.div_step && !status.div_last) begin
        bit_cnt <= bit_cnt - 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum    <= '0;
      y_accum    <= '0;
      x_step_inc <= '0;
      y_step_inc <= '0;
    end else begin
      if (cmd.start) begin
        x_accum    <= {start_x, {FRAC_BITS{1'b0}}};
        y_accum    <= {start_y, {FRAC_BITS{1'b0}}};
        x_step_inc <= '0;
        y_step_inc <= '0;
      end else if (cmd.advance && line_active) begin
        x_accum <= new_x;
        y_accum <= new_y;
      end
      if (cmd.div_step && status.div_last) begin
        x_step_inc <= neg_x ? -signed'({1'b0, quo_x_next}) : signed'({1'b0, quo_x_next});
        y_step_inc <= neg_y ? -signed'({1'b0, quo_y_next}) : signed'({1'b0, quo_y_next});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      divisor <= steps;
      rem_x   <= {1'b0, adx};
      rem_y   <= {1'b0, ady};
      quo_x   <= '0;
      quo_y   <= '0;
      neg_x   <= (end_x < start_x);
      neg_y   <= (end_y < start_y);
    end else if (cmd.div_step) begin
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
      quo_x <= quo_x_next;
      quo_y <= quo_y_next;
    end
  end

  // Output register, written once for every item transferred in.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      valid_res <= 1'b1;
      point_x   <= {start_x, {FRAC_BITS{1'b0}}};
      point_y   <= {start_y, {FRAC_BITS{1'b0}}};
      last      <= status.zero_len;
    end else if (cmd.advance) begin
      if (line_active) begin
        valid_res <= 1'b1;
        point_x   <= new_x;
        point_y   <= new_y;
        last      <= (points_left_next == '0);
      end else begin
        valid_res <= 1'b0;
        point_x   <= '0;
        point_y   <= '0;
        last      <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/dda_line_point_generator.sv @@
`timescale 1ns / 1ps

// DDA line rasteriser. A start item (op = 0) returns the first endpoint at once,
// in unsigned Q(COORD_BITS).FRAC_BITS, and then runs a restoring divider that
// retires one quotient bit of both per-step increments per cycle; no item is
// taken while the divider runs. A zero-length line skips the divider, and its
// single point carries last. Each advance item (op = 1) adds the signed
// Q1.FRAC_BITS increments, clamps to the screen range and returns the next
// point, with last on the final one. An advance with no line in progress
// returns valid_res = 0 and zero fields. One result is produced per item, and
// while no division runs the next item is taken in the cycle the held result
// is transferred.

module dda_line_point_generator #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [COORD_BITS-1:0]           start_x,
  input  logic [COORD_BITS-1:0]           start_y,
  input  logic [COORD_BITS-1:0]           end_x,
  input  logic [COORD_BITS-1:0]           end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            valid_res,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_x,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_y,
  output logic                            last
);
  import dda_pkg::*;

  dda_cmd_t    cmd;
  dda_status_t status;

  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dda_dpath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .valid_res (valid_res),
    .point_x   (point_x),
    .point_y   (point_y),
    .last      (last)
  );

endmodule

@@ bench/dda_line_point_generator_test.sv @@
`timescale 1ns / 1ps

module dda_line_point_generator_test;
  import dda_pkg::*;

  localparam int     CB          = 10;
  localparam int     FB          = 16;
  localparam int     PW          = CB + FB;
  localparam longint POS_TOP     = longint'((1 << CB) - 1) << FB;
  localparam longint ONE_FIX     = longint'(1) << FB;
  localparam int     ITEMS       = 1200;
  localparam int     HOLD_CYCLES = 300;

  typedef struct {
    logic          op;
    logic [CB-1:0] sx, sy, ex, ey;
    bit            drain;
  } line_cmd_t;

  typedef struct {
    logic          valid_res;
    logic [PW-1:0] x, y;
    logic          last;
  } point_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          op = OP_START;
  logic [CB-1:0] start_x = '0;
  logic [CB-1:0] start_y = '0;
  logic [CB-1:0] end_x = '0;
  logic [CB-1:0] end_y = '0;
  logic          out_valid;
  logic          out_ready;
  logic          ready_rx = 1'b0;
  logic          valid_res;
  logic [PW-1:0] point_x;
  logic [PW-1:0] point_y;
  logic          last;

  line_cmd_t pending[$];
  point_t    awaited[$];

  // Predicted line state.
  bit                   pen_active;
  logic [PW-1:0]        pos_x, pos_y;
  logic signed [FB+1:0] inc_x, inc_y;
  int                   steps_left;

  int  tx_wait = 0;
  int  rx_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  drain_req = 0;
  int  n_sent = 0;
  int  n_results = 0;
  int  n_errors = 0;
  int  n_starts = 0;
  int  n_zero = 0;
  int  n_adv = 0;
  int  n_idle = 0;
  int  n_last = 0;

  dda_line_point_generator #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .valid_res(valid_res),
    .point_x  (point_x),
    .point_y  (point_y),
    .last     (last)
  );

  assign out_ready = ready_rx && (hold_left == 0);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_pos(longint v);
    if (v < 0) return 0;
    if (v > POS_TOP) return POS_TOP;
    return v;
  endfunction

  function automatic longint span_of(longint sx, longint sy, longint ex, longint ey);
    longint ax, ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return (ax > ay) ? ax : ay;
  endfunction

  // Advances the predicted line by one item and returns the point it yields.
  function automatic point_t next_point(line_cmd_t c);
    point_t p;
    longint dx, dy, span;
    p.valid_res = 1'b1;
    p.last      = 1'b0;
    if (c.op == OP_START) begin
      n_starts++;
      dx    = longint'(c.ex) - longint'(c.sx);
      dy    = longint'(c.ey) - longint'(c.sy);
      span  = span_of(longint'(c.sx), longint'(c.sy), longint'(c.ex), longint'(c.ey));
      pos_x = {c.sx, {FB{1'b0}}};
      pos_y = {c.sy, {FB{1'b0}}};
      if (span == 0) begin
        n_zero++;
        inc_x      = '0;
        inc_y      = '0;
        steps_left = 0;
        pen_active = 0;
        p.last     = 1'b1;
      end else begin
        inc_x      = (FB + 2)'((dx * ONE_FIX) / span);
        inc_y      = (FB + 2)'((dy * ONE_FIX) / span);
        steps_left = int'(span);
        pen_active = 1;
      end
    end else begin
      n_adv++;
      if (!pen_active) begin
        p.valid_res = 1'b0;
        p.x         = '0;
        p.y         = '0;
        return p;
      end
      pos_x = PW'(clamp_pos(longint'(pos_x) + longint'(inc_x)));
      pos_y = PW'(clamp_pos(longint'(pos_y) + longint'(inc_y)));
      if (steps_left > 0) steps_left--;
      if (steps_left == 0) begin
        pen_active = 0;
        p.last     = 1'b1;
      end
    end
    p.x = pos_x;
    p.y = pos_y;
    return p;
  endfunction

  // Every third stretch of 150 transfers runs without idling on either side.
  function automatic int idle_draw();
    if ((n_sent / 150) % 3 == 2) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [PW-1:0] got, logic [PW-1:0] want);
    n_errors++;
    $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
             n_results, what, got, want);
  endtask

  task automatic add_item(logic op_code, int sx, int sy, int ex, int ey);
    line_cmd_t c;
    c.op      = op_code;
    c.sx      = CB'(sx);
    c.sy      = CB'(sy);
    c.ex      = CB'(ex);
    c.ey      = CB'(ey);
    c.drain   = drain_req;
    drain_req = 0;
    pending.push_back(c);
  endtask

  // Advances carry random coordinates, which the block must ignore.
  task automatic add_line(int sx, int sy, int ex, int ey, int advances);
    add_item(OP_START, sx, sy, ex, ey);
    repeat (advances) add_item(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (1 << CB) - 1;
      default: return $urandom_range(0, (1 << CB) - 1);
    endcase
  endfunction

  function automatic int clip(int v);
    if (v < 0) return 0;
    if (v > (1 << CB) - 1) return (1 << CB) - 1;
    return v;
  endfunction

  // Sender: presents the next pending item and predicts its point at once, so
  // that the expectation is always in place before the result can appear.
  always @(posedge clk) begin : tx_side
    line_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) n_sent++;
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait  <= tx_wait - 1;
      end else if (pending.size() > 0 && !(pending[0].drain && awaited.size() > 0)) begin
        c = pending.pop_front();
        op       <= c.op;
        start_x  <= c.sx;
        start_y  <= c.sy;
        end_x    <= c.ex;
        end_y    <= c.ey;
        in_valid <= 1'b1;
        awaited.push_back(next_point(c));
        tx_wait  <= idle_draw();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each transferred point against the oldest prediction.
  always @(posedge clk) begin : rx_side
    int     w;
    point_t e;
    if (rst) begin
      ready_rx <= 1'b0;
      rx_wait  <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && out_ready) begin
        n_results++;
        if (awaited.size() == 0) begin
          report_mismatch("point with nothing awaited, point_x", point_x, '0);
        end else begin
          e = awaited.pop_front();
          if (valid_res !== e.valid_res)
            report_mismatch("valid_res", PW'(valid_res), PW'(e.valid_res));
          if (point_x !== e.x) report_mismatch("point_x", point_x, e.x);
          if (point_y !== e.y) report_mismatch("point_y", point_y, e.y);
          if (last !== e.last) report_mismatch("last", PW'(last), PW'(e.last));
        end
        if (valid_res === 1'b0) n_idle++;
        if (valid_res === 1'b1 && last === 1'b1) n_last++;
        w = idle_draw();
      end else if (w > 0) begin
        w--;
      end
      rx_wait  <= w;
      ready_rx <= (w == 0);
    end
  end

  // One long hold-off on the result side while items are still on offer.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= 300 && in_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1;
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d points still awaited", awaited.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int kind, reach, sx, sy, ex, ey, span, adv, long_left, next_drain;
    long_left  = 2;
    next_drain = 150;

    // Zero-length lines at both corners, and an advance with no line.
    add_line(1023, 1023, 1023, 1023, 0);
    add_item(OP_ADVANCE, 1023, 1023, 1023, 1023);
    add_line(0, 0, 0, 0, 1);
    // Shallow line run to its end, then one advance past it.
    add_line(0, 0, 3, 1, 4);
    // Steep line with both deltas negative.
    add_line(1023, 1023, 1021, 1020, 3);
    // A start while a line is still in progress abandons it.
    add_line(5, 5, 200, 7, 1);
    add_line(0, 1023, 2, 1021, 2);
    add_line(0, 1023, 1023, 0, 2);
    add_line(512, 300, 512, 300, 1);

    while (pending.size() < ITEMS) begin
      if (pending.size() >= next_drain) begin
        drain_req  = 1;
        next_drain += 250;
      end
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        reach = ($urandom_range(0, 4) == 0) ? 40 : 12;
        sx    = pick_coord();
        sy    = pick_coord();
        ex    = clip(sx + int'($urandom_range(0, 2 * reach)) - reach);
        ey    = clip(sy + int'($urandom_range(0, 2 * reach)) - reach);
        span  = int'(span_of(longint'(sx), longint'(sy), longint'(ex), longint'(ey)));
        case ($urandom_range(0, 5))
          0:       adv = $urandom_range(0, span);
          1:       adv = span + $urandom_range(1, 2);
          default: adv = span;
        endcase
        add_line(sx, sy, ex, ey, adv);
      end else if (kind < 17) begin
        add_line($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 5));
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 3))
          add_item($urandom_range(0, 1) ? OP_ADVANCE : OP_START,
                   $urandom, $urandom, $urandom, $urandom);
      end else if (long_left > 0) begin
        long_left--;
        sx   = pick_coord();
        sy   = pick_coord();
        ex   = clip(sx + int'($urandom_range(0, 800)) - 400);
        ey   = clip(sy + int'($urandom_range(0, 800)) - 400);
        span = int'(span_of(longint'(sx), longint'(sy), longint'(ex), longint'(ey)));
        add_line(sx, sy, ex, ey, span);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || in_valid || awaited.size() > 0) @(posedge clk);
    repeat (2 * FB + 8) @(posedge clk);

    $display("Checked %0d points: %0d line starts (%0d of zero length), %0d advances",
             n_results, n_starts, n_zero, n_adv);
    $display("%0d final points flagged, %0d advances with no line, one %0d-cycle hold-off",
             n_last, n_idle, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
